@@ src/dpt_pkg.sv @@
// Shared types, thresholds and base tables of the primality tester.
package dpt_pkg;

	localparam int unsigned NW = 64;

	// Magnitude thresholds that select the base set
	localparam logic [62:0] TH_SET0 = 63'd1373653;
	localparam logic [62:0] TH_SET1 = 63'd19471033;
	localparam logic [62:0] TH_SET2 = 63'd4759123141;
	localparam logic [62:0] TH_SET3 = 63'd154639673381;
	localparam logic [62:0] TH_SET4 = 63'd47636622961201;
	localparam logic [62:0] TH_SET5 = 63'd3770579582154547;

	// Classified work item passed from front to back
	typedef struct packed {
		logic [62:0] n;
		logic        triv;
		logic        tres;
		logic [2:0]  set;
	} work_t;

	// Request to the modular multiplier
	typedef struct packed {
		logic          start;
		logic [NW-1:0] a;
		logic [NW-1:0] b;
	} mreq_t;

	function automatic logic [2:0] base_count(input logic [2:0] set);
		logic [2:0] c;
		case (set)
			3'd0: c = 3'd2;
			3'd1: c = 3'd2;
			3'd2: c = 3'd3;
			3'd3: c = 3'd3;
			3'd4: c = 3'd4;
			3'd5: c = 3'd5;
			default: c = 3'd7;
		endcase
		return c;
	endfunction

	function automatic logic [31:0] base_of(input logic [2:0] set, input logic [2:0] idx);
		logic [31:0] v;
		v = 32'd0;
		case (set)
			3'd0: case (idx)
				3'd0: v = 32'd2;
				3'd1: v = 32'd3;
				default: v = 32'd0;
			endcase
			3'd1: case (idx)
				3'd0: v = 32'd2;
				3'd1: v = 32'd299417;
				default: v = 32'd0;
			endcase
			3'd2: case (idx)
				3'd0: v = 32'd2;
				3'd1: v = 32'd7;
				3'd2: v = 32'd61;
				default: v = 32'd0;
			endcase
			3'd3: case (idx)
				3'd0: v = 32'd15;
				3'd1: v = 32'd176006322;
				3'd2: v = 32'd4221622697;
				default: v = 32'd0;
			endcase
			3'd4: case (idx)
				3'd0: v = 32'd2;
				3'd1: v = 32'd2570940;
				3'd2: v = 32'd211991001;
				3'd3: v = 32'd3749873356;
				default: v = 32'd0;
			endcase
			3'd5: case (idx)
				3'd0: v = 32'd2;
				3'd1: v = 32'd2570940;
				3'd2: v = 32'd880937;
				3'd3: v = 32'd610386380;
				3'd4: v = 32'd4130785767;
				default: v = 32'd0;
			endcase
			default: case (idx)
				3'd0: v = 32'd2;
				3'd1: v = 32'd325;
				3'd2: v = 32'd9375;
				3'd3: v = 32'd28178;
				3'd4: v = 32'd450775;
				3'd5: v = 32'd9780504;
				3'd6: v = 32'd1795265022;
				default: v = 32'd0;
			endcase
		endcase
		return v;
	endfunction

endpackage

@@ src/deterministic_primality_test_unit.sv @@
// Top level of the deterministic primality tester for candidates below 2^63.
//
//  channel   | signals                                   | role
//  cand      | cand_valid, cand_ready, candidate         | candidate in
//  res       | res_valid, res_ready, is_prime_flag,      | verdict out
//            | range_error                               |
//
// Trivial candidates (below 9 or even) have their verdict registered in the cycle after dequeue.
// Others run one modular product at a time on the single bit-serial multiplier,
// for each base of their set, up to 7 bases.
// A two-entry queue lets candidates be taken while the back end is busy.
// Reset is asynchronous and empties the queue and the result register.
module deterministic_primality_test_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cand_valid,
	output logic        cand_ready,
	input  logic [62:0] candidate,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        is_prime_flag,
	output logic        range_error
);
	logic           q_valid, q_pop;
	dpt_pkg::work_t q_head;

	dpt_front u_front (
		.clk(clk), .arst_n(arst_n), .cand_valid(cand_valid), .cand_ready(cand_ready),
		.candidate(candidate), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
	);

	dpt_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
		.res_valid(res_valid), .res_ready(res_ready), .is_prime_flag(is_prime_flag),
		.range_error(range_error)
	);
endmodule

@@ src/dpt_front.sv @@
// Front end: accepts candidates, classifies them and queues the work.
module dpt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cand_valid,
	output logic              cand_ready,
	input  logic [62:0]       candidate,
	output logic              q_valid,
	output dpt_pkg::work_t    q_head,
	input  logic              q_pop
);
	dpt_pkg::work_t w;
	dpt_pkg::work_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push;

	// Classify: trivial answers and base set selection
	always_comb begin
		w.n = candidate;
		w.triv = 1'b1;
		w.tres = 1'b0;
		w.set = 3'd6;
		if (candidate <= 63'd1) begin
			w.tres = 1'b0;
		end else if (!candidate[0]) begin
			w.tres = (candidate == 63'd2);
		end else if (candidate <= 63'd8) begin
			w.tres = 1'b1;
		end else begin
			w.triv = 1'b0;
			if (candidate < dpt_pkg::TH_SET0) w.set = 3'd0;
			else if (candidate < dpt_pkg::TH_SET1) w.set = 3'd1;
			else if (candidate < dpt_pkg::TH_SET2) w.set = 3'd2;
			else if (candidate < dpt_pkg::TH_SET3) w.set = 3'd3;
			else if (candidate < dpt_pkg::TH_SET4) w.set = 3'd4;
			else if (candidate < dpt_pkg::TH_SET5) w.set = 3'd5;
		end
	end

	assign cand_ready = (cnt_q != 2'd2);
	assign push = cand_valid && cand_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = mem_q[rp_q];

	// Two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= w;
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

@@ src/dpt_modmul.sv @@
// Bit-serial modular multiplier, one bit of b per cycle, MSB first.
module dpt_modmul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dpt_pkg::mreq_t            req,
	input  logic [dpt_pkg::NW-1:0]    m,
	output logic                      done,
	output logic [dpt_pkg::NW-1:0]    r
);
	logic                   busy_q, done_q;
	logic [5:0]             cnt_q;
	logic [dpt_pkg::NW-1:0] r_q, a_q, b_q;
	logic [dpt_pkg::NW-1:0] t, t2, u, nxt;

	// r = 2r + bit*a, reduced twice (a < m)
	always_comb begin
		t = {r_q[dpt_pkg::NW-2:0], 1'b0};
		t2 = (t >= m) ? t - m : t;
		u = t2 + (b_q[dpt_pkg::NW-1] ? a_q : '0);
		nxt = (u >= m) ? u - m : u;
	end

	// Operand registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			r_q <= nxt;
			b_q <= {b_q[dpt_pkg::NW-2:0], 1'b0};
		end
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign r = r_q;
endmodule

@@ src/dpt_back.sv @@
// Back end: strong-probable-prime test sequencer and result register.
module dpt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  dpt_pkg::work_t    q_head,
	output logic              q_pop,
	output logic              res_valid,
	input  logic              res_ready,
	output logic              is_prime_flag,
	output logic              range_error
);
	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_TZ   = 10'b0000000010,
		ST_BASE = 10'b0000000100,
		ST_RED  = 10'b0000001000,
		ST_EXP  = 10'b0000010000,
		ST_EXPM = 10'b0000100000,
		ST_EXPS = 10'b0001000000,
		ST_CHK  = 10'b0010000000,
		ST_SQ   = 10'b0100000000,
		ST_SQW  = 10'b1000000000
	} state_t;

	state_t                 st_q;
	logic [dpt_pkg::NW-1:0] n_q, nm1_q, d_q, e_q, p_q, x_q;
	logic [5:0]             s_q, j_q;
	logic [2:0]             set_q, idx_q;
	logic                   out_v_q, prime_q;
	dpt_pkg::mreq_t         mreq_q;
	logic                   mdone;
	logic [dpt_pkg::NW-1:0] mres;

	dpt_modmul u_mul (
		.clk(clk), .arst_n(arst_n), .req(mreq_q), .m(n_q), .done(mdone), .r(mres)
	);

	assign q_pop = (st_q == ST_IDLE) && q_valid && !out_v_q;
	assign res_valid = out_v_q;
	assign is_prime_flag = prime_q;
	assign range_error = 1'b0;

	// Test sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_v_q <= 1'b0;
			prime_q <= 1'b0;
			mreq_q <= '0;
			n_q <= '0;
			nm1_q <= '0;
			d_q <= '0;
			e_q <= '0;
			p_q <= '0;
			x_q <= '0;
			s_q <= '0;
			j_q <= '0;
			set_q <= '0;
			idx_q <= '0;
		end else begin
			mreq_q.start <= 1'b0;
			if (out_v_q && res_ready) out_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_head.triv) begin
							out_v_q <= 1'b1;
							prime_q <= q_head.tres;
						end else begin
							n_q <= {1'b0, q_head.n};
							nm1_q <= {1'b0, q_head.n} - 64'd1;
							d_q <= {1'b0, q_head.n} - 64'd1;
							s_q <= 6'd0;
							set_q <= q_head.set;
							idx_q <= 3'd0;
							st_q <= ST_TZ;
						end
					end
				end
				// strip trailing zeros of n-1
				ST_TZ: begin
					if (!d_q[0]) begin
						d_q <= d_q >> 1;
						s_q <= s_q + 6'd1;
					end else begin
						st_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					if (idx_q == dpt_pkg::base_count(set_q)) begin
						out_v_q <= 1'b1;
						prime_q <= 1'b1;
						st_q <= ST_IDLE;
					end else begin
						mreq_q <= '{start: 1'b1, a: 64'd1,
							b: {32'd0, dpt_pkg::base_of(set_q, idx_q)}};
						st_q <= ST_RED;
					end
				end
				// base mod n
				ST_RED: begin
					if (mdone) begin
						if (mres == '0) begin
							idx_q <= idx_q + 3'd1;
							st_q <= ST_BASE;
						end else begin
							p_q <= mres;
							x_q <= 64'd1;
							e_q <= d_q;
							st_q <= ST_EXP;
						end
					end
				end
				ST_EXP: begin
					if (e_q == '0) begin
						st_q <= ST_CHK;
					end else if (e_q[0]) begin
						mreq_q <= '{start: 1'b1, a: x_q, b: p_q};
						st_q <= ST_EXPM;
					end else begin
						mreq_q <= '{start: 1'b1, a: p_q, b: p_q};
						st_q <= ST_EXPS;
					end
				end
				ST_EXPM: begin
					if (mdone) begin
						x_q <= mres;
						mreq_q <= '{start: 1'b1, a: p_q, b: p_q};
						st_q <= ST_EXPS;
					end
				end
				ST_EXPS: begin
					if (mdone) begin
						p_q <= mres;
						e_q <= e_q >> 1;
						st_q <= ST_EXP;
					end
				end
				ST_CHK: begin
					if (x_q == 64'd1 || x_q == nm1_q) begin
						idx_q <= idx_q + 3'd1;
						st_q <= ST_BASE;
					end else begin
						j_q <= s_q - 6'd1;
						st_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (j_q == 6'd0) begin
						out_v_q <= 1'b1;
						prime_q <= 1'b0;
						st_q <= ST_IDLE;
					end else begin
						mreq_q <= '{start: 1'b1, a: x_q, b: x_q};
						j_q <= j_q - 6'd1;
						st_q <= ST_SQW;
					end
				end
				ST_SQW: begin
					if (mdone) begin
						x_q <= mres;
						if (mres == nm1_q) begin
							idx_q <= idx_q + 3'd1;
							st_q <= ST_BASE;
						end else begin
							st_q <= ST_SQ;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ src/dpt_checker.sv @@
// Port-level checker for the primality tester, bound to the top level.
module dpt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cand_valid,
	input logic        cand_ready,
	input logic [62:0] candidate,
	input logic        res_valid,
	input logic        res_ready,
	input logic        is_prime_flag,
	input logic        range_error
);
	// a stalled result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(is_prime_flag) && $stable(range_error))
		else $error("result changed while stalled");

	// a 63-bit candidate is always in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !range_error)
		else $error("range error on in-range candidate");

	// the back end reloads only from an empty result register
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> !res_valid)
		else $error("result without gap after transaction");
endmodule

bind deterministic_primality_test_unit dpt_checker u_chk (.*);
